// ===== design/frc_pkg.sv =====
// shared types, constants and the crc-32 byte update for the frame receiver
package frc_pkg;

    localparam int CMD_W    = 2;
    localparam int CLIENT_W = 8;
    localparam int SIZE_W   = 32;
    localparam int CRC_W    = 32;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 24;
    localparam int STATUS_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DATA       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISCONNECT = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_READY    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SIZE_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd3;

    localparam logic [CRC_W-1:0]    CRC_POLY   = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0]    CRC_ONES   = 32'hFFFF_FFFF;
    localparam logic [CLIENT_W-1:0] NO_CLIENT  = 8'hFF;
    localparam logic [LEN_W-1:0]    FRAME_LENGTH_RESET = 24'd104544;

    // one input transaction
    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [CLIENT_W-1:0] client_id;
        logic [SIZE_W-1:0]   frame_size;
        logic [CRC_W-1:0]    expected_crc;
        logic [BYTE_W-1:0]   data_byte;
    } frc_item_t;

    // one output transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CLIENT_W-1:0] reply_client;
        logic [CRC_W-1:0]    computed_crc;
    } frc_result_t;

    // reply of the processing stage for the current item
    typedef struct packed {
        logic        valid;
        frc_result_t result;
    } frc_reply_t;

    // reflected crc-32 update over one byte, lsb first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== design/frc_in_stage.sv =====
// input register stage holding one transaction for the processing stage
module frc_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  frc_pkg::frc_item_t in_item,
    input  logic              advance,
    output logic              item_valid,
    output frc_pkg::frc_item_t item
);
    import frc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    frc_item_t item_reg;

    // stage frees up when its item moves on
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/frc_proc.sv =====
// transfer state, byte crc update and status decision for one item per cycle while fire is high
module frc_proc (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [frc_pkg::LEN_W-1:0]  cfg_write_data,
    input  logic                       fire,
    input  frc_pkg::frc_item_t         item,
    output frc_pkg::frc_reply_t        reply
);
    import frc_pkg::*;

    logic [LEN_W-1:0]    frame_length_reg;
    logic                receiving_reg, receiving_next;
    logic [CLIENT_W-1:0] active_client_reg, active_client_next;
    logic [LEN_W-1:0]    byte_count_reg, byte_count_next;
    logic [CRC_W-1:0]    held_crc_reg, held_crc_next;
    logic [CRC_W-1:0]    running_crc_reg, running_crc_next;

    logic [CRC_W-1:0]    crc_upd;
    logic [LEN_W-1:0]    count_upd;
    logic [CRC_W-1:0]    crc_final;
    logic                size_ok;
    logic                is_active;

    assign crc_upd   = crc_byte(running_crc_reg, item.data_byte);
    assign count_upd = byte_count_reg + 1'b1;
    assign crc_final = crc_upd ^ CRC_ONES;
    assign size_ok   = (item.frame_size == {{(SIZE_W-LEN_W){1'b0}}, frame_length_reg});
    assign is_active = (item.client_id == active_client_reg);

    // next state and reply
    always_comb
    begin
        receiving_next     = receiving_reg;
        active_client_next = active_client_reg;
        byte_count_next    = byte_count_reg;
        held_crc_next      = held_crc_reg;
        running_crc_next   = running_crc_reg;
        reply              = '0;

        case (item.command)
            CMD_START:
            begin
                reply.valid               = 1'b1;
                reply.result.reply_client = item.client_id;
                if (!size_ok)
                begin
                    reply.result.status = ST_SIZE_ERR;
                end
                else
                begin
                    reply.result.status = ST_READY;
                    receiving_next      = 1'b1;
                    active_client_next  = item.client_id;
                    held_crc_next       = item.expected_crc;
                    byte_count_next     = '0;
                    running_crc_next    = CRC_ONES;
                end
            end
            CMD_DATA:
            begin
                if (receiving_reg && is_active)
                begin
                    running_crc_next = crc_upd;
                    byte_count_next  = count_upd;
                    // frame complete
                    if (count_upd >= frame_length_reg)
                    begin
                        receiving_next            = 1'b0;
                        reply.valid               = 1'b1;
                        reply.result.reply_client = active_client_reg;
                        reply.result.computed_crc = crc_final;
                        if ((held_crc_reg != '0) && (crc_final != held_crc_reg))
                        begin
                            reply.result.status = ST_MISMATCH;
                        end
                        else
                        begin
                            reply.result.status = ST_ACCEPTED;
                            active_client_next  = NO_CLIENT;
                        end
                    end
                end
            end
            CMD_DISCONNECT:
            begin
                if (receiving_reg && is_active)
                begin
                    receiving_next     = 1'b0;
                    active_client_next = NO_CLIENT;
                    byte_count_next    = '0;
                end
            end
            default:
            begin
                reply = '0;
            end
        endcase

        if (!fire)
        begin
            reply.valid = 1'b0;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= FRAME_LENGTH_RESET;
        end
        else if (cfg_write_en)
        begin
            frame_length_reg <= cfg_write_data;
        end
    end

    // transfer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg     <= 1'b0;
            active_client_reg <= NO_CLIENT;
            byte_count_reg    <= '0;
            held_crc_reg      <= '0;
            running_crc_reg   <= CRC_ONES;
        end
        else if (fire)
        begin
            receiving_reg     <= receiving_next;
            active_client_reg <= active_client_next;
            byte_count_reg    <= byte_count_next;
            held_crc_reg      <= held_crc_next;
            running_crc_reg   <= running_crc_next;
        end
    end

endmodule

// ===== design/frame_receiver_crc32_check_core.sv =====
// top level of the crc-32 checked frame receiver
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------------------
//  input    | in_valid / in_ready        | command, client_id, frame_size, expected_crc,
//           |                            | data_byte
//  output   | out_valid / out_ready      | status, reply_client, computed_crc
//  config   | cfg_write_en               | cfg_write_data (frame_length)
//
//  one transaction per cycle sustained while the output is not stalled; a result is registered
//  when its transaction leaves the input register, and a stalled output holds it there
//  the byte-wide crc update between the input and output registers sets the cycle time
//  reset clears valid flags and transfer state at once, frame_length returns to 104544, no clearing pass;
//  payload registers are not reset; a stalled output holds the input register, which then drops in_ready
module frame_receiver_crc32_check_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [frc_pkg::LEN_W-1:0]     cfg_write_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [frc_pkg::CMD_W-1:0]     command,
    input  logic [frc_pkg::CLIENT_W-1:0]  client_id,
    input  logic [frc_pkg::SIZE_W-1:0]    frame_size,
    input  logic [frc_pkg::CRC_W-1:0]     expected_crc,
    input  logic [frc_pkg::BYTE_W-1:0]    data_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [frc_pkg::STATUS_W-1:0]  status,
    output logic [frc_pkg::CLIENT_W-1:0]  reply_client,
    output logic [frc_pkg::CRC_W-1:0]     computed_crc
);
    import frc_pkg::*;

    frc_item_t   in_item;
    frc_item_t   item;
    logic        item_valid;
    logic        advance;
    frc_reply_t  reply;

    logic        out_valid_reg, out_valid_next;
    frc_result_t result_reg;

    // pack input ports
    always_comb
    begin
        in_item.command      = command;
        in_item.client_id    = client_id;
        in_item.frame_size   = frame_size;
        in_item.expected_crc = expected_crc;
        in_item.data_byte    = data_byte;
    end

    // item moves on when the output register can take a result
    assign advance = item_valid && (!out_valid_reg || out_ready);

    frc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    frc_proc u_proc (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .fire           (advance),
        .item           (item),
        .reply          (reply)
    );

    // output register control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (reply.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (reply.valid)
        begin
            result_reg <= reply.result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = result_reg.status;
    assign reply_client = result_reg.reply_client;
    assign computed_crc = result_reg.computed_crc;

`ifndef SYNTH
    // a full input stage behind a stalled output takes nothing new
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while pipeline stalled");

    // a reply is only produced when the output register is free or draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        reply.valid |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // a produced reply shows up at the output next cycle
    a_reply_shown: assert property (@(posedge clk) disable iff (!rst_n)
        reply.valid |=> out_valid)
        else $error("reply lost");

    // ready and size error carry no crc
    a_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_READY || status == ST_SIZE_ERR)) |-> (computed_crc == '0))
        else $error("crc on non-completion status");
`endif

endmodule

// ===== tb/frame_receiver_crc32_check_checker.sv =====
// crc-32 helper package and the scoreboard that predicts and checks frame receiver replies
`timescale 1ns / 100ps

package frc_tb_pkg;

    // command value outside the defined set, must be ignored
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // reflected crc-32 update, one data bit at a time
    function automatic logic [31:0] crc32_feed_byte(input logic [31:0] acc,
                                                    input logic [7:0] data);
        logic feedback;
        for (int i = 0; i < 8; i++)
        begin
            feedback = acc[0] ^ data[i];
            acc = acc >> 1;
            if (feedback)
                acc = acc ^ 32'hEDB8_8320;
        end
        return acc;
    endfunction

endpackage

module frame_receiver_crc32_check_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [frc_pkg::LEN_W-1:0]     cfg_write_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [frc_pkg::CMD_W-1:0]     command,
    input  logic [frc_pkg::CLIENT_W-1:0]  client_id,
    input  logic [frc_pkg::SIZE_W-1:0]    frame_size,
    input  logic [frc_pkg::CRC_W-1:0]     expected_crc,
    input  logic [frc_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [frc_pkg::STATUS_W-1:0]  status,
    input  logic [frc_pkg::CLIENT_W-1:0]  reply_client,
    input  logic [frc_pkg::CRC_W-1:0]     computed_crc,
    output int                            fail_count,
    output int                            pending,
    output int                            items_seen,
    output int                            results_seen,
    output int                            frames_accepted,
    output int                            frames_mismatched
);
    import frc_pkg::*;
    import frc_tb_pkg::*;

    // predicted receiver state
    logic                receiving;
    logic [CLIENT_W-1:0] active_client;
    logic [LEN_W-1:0]    byte_count;
    logic [CRC_W-1:0]    held_crc;
    logic [CRC_W-1:0]    running_crc;
    logic [LEN_W-1:0]    frame_length;

    frc_result_t expected_replies [$];

    // apply one input transaction to the predicted state, queue any reply
    task automatic advance_receiver(input frc_item_t it);
        logic [CRC_W-1:0] final_crc;
        case (it.command)
            CMD_START:
            begin
                if (it.frame_size != {{(SIZE_W-LEN_W){1'b0}}, frame_length})
                begin
                    expected_replies.push_back('{ST_SIZE_ERR, it.client_id, '0});
                end
                else
                begin
                    receiving     = 1'b1;
                    active_client = it.client_id;
                    held_crc      = it.expected_crc;
                    byte_count    = '0;
                    running_crc   = CRC_ONES;
                    expected_replies.push_back('{ST_READY, it.client_id, '0});
                end
            end
            CMD_DATA:
            begin
                if (receiving && it.client_id == active_client)
                begin
                    running_crc = crc32_feed_byte(running_crc, it.data_byte);
                    byte_count  = byte_count + 1'b1;
                    if (byte_count >= frame_length)
                    begin
                        receiving = 1'b0;
                        final_crc = running_crc ^ CRC_ONES;
                        if (held_crc != '0 && final_crc != held_crc)
                        begin
                            // client stays recorded, transfer closed
                            expected_replies.push_back('{ST_MISMATCH, active_client, final_crc});
                        end
                        else
                        begin
                            expected_replies.push_back('{ST_ACCEPTED, active_client, final_crc});
                            active_client = NO_CLIENT;
                        end
                    end
                end
            end
            CMD_DISCONNECT:
            begin
                if (receiving && it.client_id == active_client)
                begin
                    receiving     = 1'b0;
                    active_client = NO_CLIENT;
                    byte_count    = '0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        frc_result_t want;
        if (!rst_n)
        begin
            receiving     = 1'b0;
            active_client = NO_CLIENT;
            byte_count    = '0;
            held_crc      = '0;
            running_crc   = CRC_ONES;
            frame_length  = FRAME_LENGTH_RESET;
            expected_replies.delete();
            pending       = 0;
        end
        else
        begin
            // result side first: a reply never belongs to an item taken at the same edge
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("unexpected result: status %0d client %0d crc %h",
                           status, reply_client, computed_crc);
                    fail_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    results_seen++;
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (reply_client !== want.reply_client)
                    begin
                        $error("reply_client: expected %0d, actual %0d",
                               want.reply_client, reply_client);
                        fail_count++;
                    end
                    if (computed_crc !== want.computed_crc)
                    begin
                        $error("computed_crc: expected %h, actual %h",
                               want.computed_crc, computed_crc);
                        fail_count++;
                    end
                    if (want.status == ST_ACCEPTED)
                        frames_accepted++;
                    if (want.status == ST_MISMATCH)
                        frames_mismatched++;
                end
            end

            if (cfg_write_en)
                frame_length = cfg_write_data;

            if (in_valid && in_ready)
            begin
                items_seen++;
                advance_receiver('{command, client_id, frame_size, expected_crc, data_byte});
            end

            pending = expected_replies.size();
        end
    end

endmodule

// ===== tb/frame_receiver_crc32_check_core_tb.sv =====
// stimulus, handshake idling and verdict for the crc-32 checked frame receiver
`timescale 1ns / 100ps

module frame_receiver_crc32_check_core_tb;
    import frc_pkg::*;
    import frc_tb_pkg::*;

    localparam int STALL_LIMIT      = 10000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int ITEMS_PER_PHASE  = 250;
    localparam int PHASES           = 8;
    localparam int LONGEST_FULL     = 40;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 cfg_write_en   = 1'b0;
    logic [LEN_W-1:0]     cfg_write_data = '0;
    logic                 in_valid       = 1'b0;
    logic                 in_ready;
    logic [CMD_W-1:0]     command        = '0;
    logic [CLIENT_W-1:0]  client_id      = '0;
    logic [SIZE_W-1:0]    frame_size     = '0;
    logic [CRC_W-1:0]     expected_crc   = '0;
    logic [BYTE_W-1:0]    data_byte      = '0;
    logic                 out_valid;
    logic                 out_ready      = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [CLIENT_W-1:0]  reply_client;
    logic [CRC_W-1:0]     computed_crc;

    int fail_count;
    int pending;
    int items_seen;
    int results_seen;
    int frames_accepted;
    int frames_mismatched;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int useful_items = 0;
    int idle_cycles  = 0;

    frame_receiver_crc32_check_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .client_id      (client_id),
        .frame_size     (frame_size),
        .expected_crc   (expected_crc),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .reply_client   (reply_client),
        .computed_crc   (computed_crc)
    );

    frame_receiver_crc32_check_checker scoreboard (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .client_id         (client_id),
        .frame_size        (frame_size),
        .expected_crc      (expected_crc),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .reply_client      (reply_client),
        .computed_crc      (computed_crc),
        .fail_count        (fail_count),
        .pending           (pending),
        .items_seen        (items_seen),
        .results_seen      (results_seen),
        .frames_accepted   (frames_accepted),
        .frames_mismatched (frames_mismatched)
    );

    // 4 ns clock
    always #2 clk = ~clk;

    // receiver stalls at random per cycle
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic frc_item_t make_item(input logic [CMD_W-1:0] cmd,
                                            input logic [CLIENT_W-1:0] cl,
                                            input logic [SIZE_W-1:0] size,
                                            input logic [CRC_W-1:0] crc,
                                            input logic [BYTE_W-1:0] db);
        frc_item_t it;
        it = '{cmd, cl, size, crc, db};
        return it;
    endfunction

    // present one transaction, with random sender gaps, and wait until taken
    task automatic send_item(input frc_item_t it);
        @(negedge clk);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= it.command;
        client_id    <= it.client_id;
        frame_size   <= it.frame_size;
        expected_crc <= it.expected_crc;
        data_byte    <= it.data_byte;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // sender holds off until every reply is in, then lets the pipeline empty
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_frame_length(input logic [LEN_W-1:0] len);
        wait_quiet();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= len;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // one well-formed frame with random content, sometimes cut short
    task automatic send_frame(input logic [LEN_W-1:0] len);
        logic [BYTE_W-1:0]   frame_data [0:63];
        logic [CLIENT_W-1:0] owner;
        logic [CRC_W-1:0]    crc_acc;
        logic [CRC_W-1:0]    announced;
        int                  n_bytes;
        int                  pick;
        bit                  truncated;
        owner     = 8'($urandom_range(255));
        truncated = (len > LONGEST_FULL);
        n_bytes   = truncated ? $urandom_range(1, 24) : int'(len);
        crc_acc   = CRC_ONES;
        for (int i = 0; i < n_bytes; i++)
        begin
            frame_data[i] = 8'($urandom_range(255));
            crc_acc = crc32_feed_byte(crc_acc, frame_data[i]);
        end
        crc_acc = crc_acc ^ CRC_ONES;

        // skip check, good crc or corrupted crc
        pick = $urandom_range(99);
        if (pick < 20)
            announced = '0;
        else if (pick < 70)
            announced = crc_acc;
        else
            announced = crc_acc ^ ($urandom | 32'h1);

        send_item(make_item(CMD_START, owner, {8'h00, len}, announced,
                            8'($urandom_range(255))));
        useful_items++;

        for (int i = 0; i < n_bytes; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                // owner drops the link mid-frame
                send_item(make_item(CMD_DISCONNECT, owner, $urandom, $urandom,
                                    8'($urandom_range(255))));
                return;
            end
            if (pick < 5)
            begin
                // another client takes over with a valid start
                send_item(make_item(CMD_START, owner ^ 8'($urandom_range(1, 255)),
                                    {8'h00, len}, $urandom, 8'($urandom_range(255))));
                useful_items++;
                return;
            end
            if (pick < 20)
            begin
                // interleaved traffic from some other client
                send_item(make_item(($urandom_range(1)) ? CMD_DATA : CMD_DISCONNECT,
                                    owner ^ 8'($urandom_range(1, 255)), $urandom, $urandom,
                                    8'($urandom_range(255))));
            end
            send_item(make_item(CMD_DATA, owner, $urandom, $urandom, frame_data[i]));
            useful_items++;
        end
        if (truncated)
            send_item(make_item(CMD_DISCONNECT, owner, $urandom, $urandom,
                                8'($urandom_range(255))));
    endtask

    // stray or malformed transaction
    task automatic send_noise(input logic [LEN_W-1:0] len);
        logic [SIZE_W-1:0] size;
        int                pick;
        pick = $urandom_range(3);
        case (pick)
            0:
            begin
                case ($urandom_range(2))
                    0: size = $urandom;
                    1: size = {8'h00, len} + ($urandom_range(1) ? 32'd1 : -32'd1);
                    default: size = {8'($urandom_range(1, 255)), len};
                endcase
                if (size == {8'h00, len})
                    size = size ^ 32'h1;
                send_item(make_item(CMD_START, 8'($urandom_range(255)), size, $urandom,
                                    8'($urandom_range(255))));
            end
            1: send_item(make_item(CMD_DATA, 8'($urandom_range(255)), $urandom, $urandom,
                                   8'($urandom_range(255))));
            2: send_item(make_item(CMD_DISCONNECT, 8'($urandom_range(255)), $urandom,
                                   $urandom, 8'($urandom_range(255))));
            default: send_item(make_item(CMD_UNUSED, 8'($urandom_range(255)), $urandom,
                                         $urandom, 8'($urandom_range(255))));
        endcase
    endtask

    initial
    begin
        logic [LEN_W-1:0] len;
        int               target;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset length, client 255 as owner, disconnect abort
        send_item(make_item(CMD_START, 8'h00, 32'hFFFF_FFFF, 32'h0, 8'h00));
        send_item(make_item(CMD_START, 8'hFF, {8'h00, FRAME_LENGTH_RESET}, 32'h0, 8'hFF));
        send_item(make_item(CMD_DATA, 8'hFF, 32'h0, 32'h0, 8'hFF));
        send_item(make_item(CMD_DATA, 8'h00, 32'h0, 32'h0, 8'h00));
        send_item(make_item(CMD_DISCONNECT, 8'hFF, 32'h0, 32'h0, 8'h00));
        send_item(make_item(CMD_DATA, 8'hFF, 32'h0, 32'h0, 8'h12));

        // directed: one-byte frames, skip, good and bad crc
        set_frame_length(24'd1);
        send_item(make_item(CMD_START, 8'h00, 32'd1, 32'h0, 8'h00));
        send_item(make_item(CMD_DATA, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00));
        send_item(make_item(CMD_START, 8'hAA, 32'd1,
                            crc32_feed_byte(CRC_ONES, 8'hFF) ^ CRC_ONES, 8'h00));
        send_item(make_item(CMD_DATA, 8'hAA, 32'h0, 32'h0, 8'hFF));
        send_item(make_item(CMD_START, 8'h55, 32'd1, 32'hFFFF_FFFF, 8'h00));
        send_item(make_item(CMD_DATA, 8'h55, 32'h0, 32'h0, 8'h5A));
        // after a mismatch: disconnect does nothing, data is ignored
        send_item(make_item(CMD_DISCONNECT, 8'h55, 32'h0, 32'h0, 8'h00));
        send_item(make_item(CMD_DATA, 8'h55, 32'h0, 32'h0, 8'h55));
        send_item(make_item(CMD_UNUSED, 8'h55, 32'd1, 32'hFFFF_FFFF, 8'hFF));
        // upper size bits set, then zero size
        send_item(make_item(CMD_START, 8'h01, 32'h0100_0001, 32'h0, 8'h00));
        send_item(make_item(CMD_START, 8'h02, 32'h0, 32'h0, 8'h00));
        // a second valid start takes the transfer over
        send_item(make_item(CMD_START, 8'h07, 32'd1, 32'h0, 8'h00));
        send_item(make_item(CMD_START, 8'h09, 32'd1, 32'h0, 8'h00));
        send_item(make_item(CMD_DATA, 8'h07, 32'h0, 32'h0, 8'h33));
        send_item(make_item(CMD_DATA, 8'h09, 32'h0, 32'h0, 8'hC3));

        // directed: largest length
        set_frame_length(24'hFF_FFFF);
        send_item(make_item(CMD_START, 8'h80, 32'h00FF_FFFF, 32'hFFFF_FFFF, 8'h00));
        send_item(make_item(CMD_DATA, 8'h80, 32'h0, 32'h0, 8'hA5));
        send_item(make_item(CMD_START, 8'h81, 32'hFFFF_FFFF, 32'h0, 8'h00));
        send_item(make_item(CMD_DISCONNECT, 8'h80, 32'h0, 32'h0, 8'h00));

        // random phases over lengths and idling mixes
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: len = 24'd1;
                2: len = 24'hFF_FFFF;
                5: len = 24'(LONGEST_FULL);
                default: len = 24'($urandom_range(2, 12));
            endcase
            set_frame_length(len);
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
                default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
            endcase
            target = useful_items + ITEMS_PER_PHASE;
            while (useful_items < target)
            begin
                if ($urandom_range(99) < 80)
                    send_frame(len);
                else
                    send_noise(len);
            end
        end

        wait_quiet();
        repeat (10) @(negedge clk);

        $display("run: %0d transactions, %0d replies, %0d frames accepted, %0d crc mismatches",
                 items_seen, results_seen, frames_accepted, frames_mismatched);
        $display("frame lengths 1 to %0d plus the largest, under four sender/receiver idle mixes",
                 LONGEST_FULL);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
